FILE: hw/rtl/jsgp_pkg.sv
// Package for the joystick event to gamepad report block.
// Event and report types, event codes, hat codes and the button map.
// No dependencies.
`default_nettype none

package jsgp_pkg;

  typedef struct packed {
    logic [7:0]         event_type;
    logic [7:0]         control_number;
    logic signed [15:0] event_value;
  } event_t;

  typedef struct packed {
    logic [15:0] button_mask;
    logic [3:0]  hat_code;
    logic [7:0]  left_stick_x;
    logic [7:0]  left_stick_y;
    logic [7:0]  right_stick_x;
    logic [7:0]  right_stick_y;
  } report_t;

  localparam logic [6:0] KIND_BUTTON = 7'd1;
  localparam logic [6:0] KIND_AXIS   = 7'd2;

  localparam logic [7:0] NUM_BUTTONS = 8'd12;

  localparam logic [7:0] AXIS_LEFT_X    = 8'd0;
  localparam logic [7:0] AXIS_LEFT_Y    = 8'd1;
  localparam logic [7:0] AXIS_TRIG_L    = 8'd2;
  localparam logic [7:0] AXIS_RIGHT_X   = 8'd3;
  localparam logic [7:0] AXIS_RIGHT_Y   = 8'd4;
  localparam logic [7:0] AXIS_TRIG_R    = 8'd5;
  localparam logic [7:0] AXIS_HAT_HORIZ = 8'd6;
  localparam logic [7:0] AXIS_HAT_VERT  = 8'd7;

  localparam logic [3:0] TRIG_L_BIT = 4'd6;
  localparam logic [3:0] TRIG_R_BIT = 4'd7;

  localparam logic signed [15:0] HAT_AXIS_NEG = -16'sd32767;
  localparam logic signed [15:0] HAT_AXIS_POS = 16'sd32767;

  localparam logic signed [15:0] TRIG_THRESHOLD_RESET = -16'sd29000;

  localparam logic [3:0] HAT_UP         = 4'd0;
  localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
  localparam logic [3:0] HAT_EAST       = 4'd2;
  localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
  localparam logic [3:0] HAT_DOWN       = 4'd4;
  localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
  localparam logic [3:0] HAT_WEST       = 4'd6;
  localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
  localparam logic [3:0] HAT_IDLE       = 4'd8;

  // report bit for button controls 0..11
  function automatic logic [3:0] button_bit(input logic [3:0] num);
    logic [3:0] b;
    case (num)
      4'd0:    b = 4'd1;
      4'd1:    b = 4'd2;
      4'd2:    b = 4'd0;
      4'd3:    b = 4'd3;
      4'd4:    b = 4'd4;
      4'd5:    b = 4'd5;
      4'd6:    b = 4'd8;
      4'd7:    b = 4'd9;
      4'd8:    b = 4'd12;
      4'd9:    b = 4'd10;
      4'd10:   b = 4'd11;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/jsgp_event_if.sv
// Event channel interface: valid/ready handshake with the joystick event fields.
// No dependencies.
`default_nettype none

interface jsgp_event_if;
  logic               valid;
  logic               ready;
  logic [7:0]         event_type;
  logic [7:0]         control_number;
  logic signed [15:0] event_value;

  modport source (output valid, output event_type, output control_number,
                  output event_value, input ready);
  modport sink   (input valid, input event_type, input control_number,
                  input event_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/jsgp_report_if.sv
// Report channel interface: valid/ready handshake with the gamepad report fields.
// No dependencies.
`default_nettype none

interface jsgp_report_if;
  logic        valid;
  logic        ready;
  logic [15:0] button_mask;
  logic [3:0]  hat_code;
  logic [7:0]  left_stick_x;
  logic [7:0]  left_stick_y;
  logic [7:0]  right_stick_x;
  logic [7:0]  right_stick_y;

  modport source (output valid, output button_mask, output hat_code,
                  output left_stick_x, output left_stick_y,
                  output right_stick_x, output right_stick_y, input ready);
  modport sink   (input valid, input button_mask, input hat_code,
                  input left_stick_x, input left_stick_y,
                  input right_stick_x, input right_stick_y, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/jsgp_in_stage.sv
// Input register stage: captures one event per transfer on the event channel.
// Depends on jsgp_pkg and jsgp_event_if.
`default_nettype none

module jsgp_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  jsgp_event_if.sink          evt,
  input  wire logic           advance,
  output logic                stage_valid,
  output jsgp_pkg::event_t    stage_event
);
  import jsgp_pkg::*;

  assign evt.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (evt.ready) begin
      stage_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      stage_event.event_type     <= evt.event_type;
      stage_event.control_number <= evt.control_number;
      stage_event.event_value    <= evt.event_value;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/jsgp_update.sv
// Report update logic: applies one event to the held report.
// Depends on jsgp_pkg.
`default_nettype none

module jsgp_update (
  input  jsgp_pkg::report_t         held,
  input  jsgp_pkg::event_t          ev,
  input  wire logic signed [15:0]   threshold,
  output jsgp_pkg::report_t         updated
);
  import jsgp_pkg::*;

  function automatic logic [3:0] hat_compose(input logic up, input logic down,
                                             input logic left, input logic right);
    logic [3:0] c;
    if (up) begin
      c = left ? HAT_UP_LEFT : (right ? HAT_UP_RIGHT : HAT_UP);
    end else if (down) begin
      c = left ? HAT_DOWN_LEFT : (right ? HAT_DOWN_RIGHT : HAT_DOWN);
    end else begin
      c = left ? HAT_WEST : (right ? HAT_EAST : HAT_IDLE);
    end
    return c;
  endfunction

  logic [6:0] kind;
  logic [7:0] shaped;
  logic       trig_on;
  logic       val_neg;
  logic       val_pos;
  logic       held_up;
  logic       held_down;
  logic       held_left;
  logic       held_right;
  logic [3:0] btn_bit;

  assign kind    = ev.event_type[6:0];
  // (value + 32768) >> 8
  assign shaped  = {~ev.event_value[15], ev.event_value[14:8]};
  assign trig_on = ev.event_value > threshold;
  assign val_neg = ev.event_value == HAT_AXIS_NEG;
  assign val_pos = ev.event_value == HAT_AXIS_POS;
  assign btn_bit = button_bit(ev.control_number[3:0]);

  assign held_up    = (held.hat_code == HAT_UP) || (held.hat_code == HAT_UP_RIGHT) ||
                      (held.hat_code == HAT_UP_LEFT);
  assign held_down  = (held.hat_code == HAT_DOWN_RIGHT) || (held.hat_code == HAT_DOWN) ||
                      (held.hat_code == HAT_DOWN_LEFT);
  assign held_left  = (held.hat_code == HAT_DOWN_LEFT) || (held.hat_code == HAT_WEST) ||
                      (held.hat_code == HAT_UP_LEFT);
  assign held_right = (held.hat_code == HAT_UP_RIGHT) || (held.hat_code == HAT_EAST) ||
                      (held.hat_code == HAT_DOWN_RIGHT);

  always_comb begin
    updated = held;
    if (kind == KIND_BUTTON) begin
      if (ev.control_number < NUM_BUTTONS) begin
        updated.button_mask[btn_bit] = ev.event_value != 16'sd0;
      end
    end else if (kind == KIND_AXIS) begin
      case (ev.control_number)
        AXIS_LEFT_X:    updated.left_stick_x  = shaped;
        AXIS_LEFT_Y:    updated.left_stick_y  = shaped;
        AXIS_RIGHT_X:   updated.right_stick_x = shaped;
        AXIS_RIGHT_Y:   updated.right_stick_y = shaped;
        AXIS_TRIG_L:    updated.button_mask[TRIG_L_BIT] = trig_on;
        AXIS_TRIG_R:    updated.button_mask[TRIG_R_BIT] = trig_on;
        AXIS_HAT_HORIZ: updated.hat_code = hat_compose(held_up, held_down, val_neg, val_pos);
        AXIS_HAT_VERT:  updated.hat_code = hat_compose(val_neg, val_pos, held_left, held_right);
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/joystick_event_to_gamepad_report.sv
// Joystick event to gamepad report, top level.
// Each event is held in the input stage register, then its result in report_q.
// Throughput: one event per cycle unless rpt stalls; update is combinational.
// Reset (rst, synchronous): report state cleared, hat code top, threshold -29000.
// Depends on jsgp_pkg, jsgp_event_if, jsgp_report_if, jsgp_in_stage, jsgp_update.
`default_nettype none

module joystick_event_to_gamepad_report (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic signed [15:0] cfg_wdata,
  jsgp_event_if.sink              evt,
  jsgp_report_if.source           rpt
);
  import jsgp_pkg::*;

  logic               stage_valid;
  event_t             stage_event;
  logic               advance;
  logic signed [15:0] threshold;
  report_t            held;
  report_t            held_next;
  report_t            report_q;
  logic               out_valid;

  assign advance = !out_valid || rpt.ready;

  jsgp_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .evt         (evt),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_event (stage_event)
  );

  jsgp_update u_update (
    .held      (held),
    .ev        (stage_event),
    .threshold (threshold),
    .updated   (held_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= TRIG_THRESHOLD_RESET;
    end else if (cfg_wen) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= stage_valid;
      end
      if (stage_valid && advance) begin
        held <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && advance) begin
      report_q <= held_next;
    end
  end

  assign rpt.valid         = out_valid;
  assign rpt.button_mask   = report_q.button_mask;
  assign rpt.hat_code      = report_q.hat_code;
  assign rpt.left_stick_x  = report_q.left_stick_x;
  assign rpt.left_stick_y  = report_q.left_stick_y;
  assign rpt.right_stick_x = report_q.right_stick_x;
  assign rpt.right_stick_y = report_q.right_stick_y;

`ifndef SYNTHESIS
  a_hat_range: assert property (@(posedge clk) disable iff (rst)
    rpt.valid |-> rpt.hat_code <= HAT_IDLE)
    else $error("hat code out of range");

  a_unmapped_bits: assert property (@(posedge clk) disable iff (rst)
    rpt.valid |-> rpt.button_mask[15:13] == 3'b000)
    else $error("unmapped button bit set");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && advance) |=> rpt.valid)
    else $error("event transfer produced no report");

  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    !(stage_valid && advance) |=> $stable(held))
    else $error("held report changed without an event");
`endif

endmodule

`default_nettype wire

FILE: test/joystick_event_to_gamepad_report_tb.sv
// Testbench for joystick_event_to_gamepad_report: event stream in, report per event out.
// A shadow copy of the held report predicts each report; results are checked in order.
// Depends on jsgp_pkg, jsgp_event_if, jsgp_report_if and the block itself.
`timescale 1ns / 1ps

module joystick_event_to_gamepad_report_tb;
  import jsgp_pkg::*;

  localparam logic [7:0] INIT_FLAG = 8'h80;
  localparam logic [7:0] BTN       = {1'b0, KIND_BUTTON};
  localparam logic [7:0] AXS       = {1'b0, KIND_AXIS};
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 270;
  localparam int LONG_HOLD  = 64;

  // shadow of the held report plus the queue of reports still owed
  class gamepad_shadow;
    report_t            held;
    logic signed [15:0] threshold;
    logic [3:0]         bit_of_button [12];
    report_t            pending_reports [$];
    int                 mismatch_count;

    function new();
      held = '0;
      held.hat_code = HAT_UP;
      threshold = TRIG_THRESHOLD_RESET;
      bit_of_button = '{4'd1, 4'd2, 4'd0, 4'd3, 4'd4, 4'd5,
                        4'd8, 4'd9, 4'd12, 4'd10, 4'd11, 4'd0};
      mismatch_count = 0;
    endfunction

    function logic [3:0] hat_of(int v, int h);
      if (v < 0) return h < 0 ? HAT_UP_LEFT : (h > 0 ? HAT_UP_RIGHT : HAT_UP);
      if (v > 0) return h < 0 ? HAT_DOWN_LEFT : (h > 0 ? HAT_DOWN_RIGHT : HAT_DOWN);
      return h < 0 ? HAT_WEST : (h > 0 ? HAT_EAST : HAT_IDLE);
    endfunction

    function void take_event(event_t ev);
      logic [6:0] kind;
      logic [3:0] hc;
      logic [7:0] level;
      int pos, v_held, h_held, dir;
      kind   = ev.event_type[6:0];
      pos    = ev.event_value;
      level  = 8'((pos + 32768) >> 8);
      hc     = held.hat_code;
      v_held = (hc inside {HAT_UP, HAT_UP_RIGHT, HAT_UP_LEFT}) ? -1 :
               ((hc inside {HAT_DOWN_RIGHT, HAT_DOWN, HAT_DOWN_LEFT}) ? 1 : 0);
      h_held = (hc inside {HAT_DOWN_LEFT, HAT_WEST, HAT_UP_LEFT}) ? -1 :
               ((hc inside {HAT_UP_RIGHT, HAT_EAST, HAT_DOWN_RIGHT}) ? 1 : 0);
      dir    = (pos == HAT_AXIS_NEG) ? -1 : ((pos == HAT_AXIS_POS) ? 1 : 0);
      if (kind == KIND_BUTTON) begin
        if (ev.control_number < NUM_BUTTONS)
          held.button_mask[bit_of_button[ev.control_number]] = (pos != 0);
      end else if (kind == KIND_AXIS) begin
        case (ev.control_number)
          AXIS_LEFT_X:    held.left_stick_x = level;
          AXIS_LEFT_Y:    held.left_stick_y = level;
          AXIS_RIGHT_X:   held.right_stick_x = level;
          AXIS_RIGHT_Y:   held.right_stick_y = level;
          AXIS_TRIG_L:    held.button_mask[TRIG_L_BIT] = (pos > int'(threshold));
          AXIS_TRIG_R:    held.button_mask[TRIG_R_BIT] = (pos > int'(threshold));
          AXIS_HAT_HORIZ: held.hat_code = hat_of(v_held, dir);
          AXIS_HAT_VERT:  held.hat_code = hat_of(dir, h_held);
          default: ;
        endcase
      end
      pending_reports.push_back(held);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %h", $time, got);
        mismatch_count++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("button_mask", want.button_mask, got.button_mask);
      compare_field("hat_code", 16'(want.hat_code), 16'(got.hat_code));
      compare_field("left_stick_x", 16'(want.left_stick_x), 16'(got.left_stick_x));
      compare_field("left_stick_y", 16'(want.left_stick_y), 16'(got.left_stick_y));
      compare_field("right_stick_x", 16'(want.right_stick_x), 16'(got.right_stick_x));
      compare_field("right_stick_y", 16'(want.right_stick_y), 16'(got.right_stick_y));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen;
  logic signed [15:0] cfg_wdata;

  jsgp_event_if  evt_if ();
  jsgp_report_if rpt_if ();

  gamepad_shadow shadow = new();

  logic signed [15:0] trigger_level = TRIG_THRESHOLD_RESET;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  bit long_hold_pending = 1'b0;

  joystick_event_to_gamepad_report i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .evt       (evt_if),
    .rpt       (rpt_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // transfers on both channels
  always @(posedge clk) begin
    report_t got;
    if (!rst) begin
      if (evt_if.valid && evt_if.ready)
        shadow.take_event({evt_if.event_type, evt_if.control_number, evt_if.event_value});
      if (rpt_if.valid && rpt_if.ready) begin
        got.button_mask   = rpt_if.button_mask;
        got.hat_code      = rpt_if.hat_code;
        got.left_stick_x  = rpt_if.left_stick_x;
        got.left_stick_y  = rpt_if.left_stick_y;
        got.right_stick_x = rpt_if.right_stick_x;
        got.right_stick_y = rpt_if.right_stick_y;
        shadow.check_report(got);
      end
    end
  end

  // report sink: random stalls, one long hold on request
  initial begin
    rpt_if.ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        rpt_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        rpt_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        rpt_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_event(input event_t ev);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    evt_if.valid          <= 1'b1;
    evt_if.event_type     <= ev.event_type;
    evt_if.control_number <= ev.control_number;
    evt_if.event_value    <= ev.event_value;
    do @(posedge clk); while (!evt_if.ready);
  endtask

  task automatic wait_idle();
    evt_if.valid <= 1'b0;
    while (shadow.pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic signed [15:0] thr);
    cfg_wen   <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_wen <= 1'b0;
    shadow.threshold = thr;
    trigger_level = thr;
  endtask

  function automatic event_t random_event();
    event_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    ev.event_value = 16'($urandom);
    ev.event_type  = BTN | (($urandom_range(0, 4) == 0) ? INIT_FLAG : 8'h00);
    if (pick < 40) begin
      ev.control_number = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
      if ($urandom_range(0, 1)) ev.event_value = '0;
    end else if (pick < 90) begin
      ev.event_type[6:0] = KIND_AXIS;
      ev.control_number = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      case ($urandom_range(0, 6))
        0: ev.event_value = HAT_AXIS_NEG;
        1: ev.event_value = HAT_AXIS_POS;
        2: ev.event_value = 16'sh8000;
        3: ev.event_value = 16'(trigger_level + $urandom_range(0, 2) - 1);
        default: ;
      endcase
    end else begin
      ev.event_type     = 8'($urandom);
      ev.control_number = 8'($urandom);
    end
    return ev;
  endfunction

  initial begin
    event_t opening [$];
    logic signed [15:0] levels [PHASES];
    evt_if.valid          <= 1'b0;
    evt_if.event_type     <= '0;
    evt_if.control_number <= '0;
    evt_if.event_value    <= '0;
    cfg_wen               <= 1'b0;
    cfg_wdata             <= '0;
    levels = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'($urandom),
               TRIG_THRESHOLD_RESET, 16'($urandom)};
    opening = '{
      '{BTN, 8'd0, 16'sd1},
      '{BTN | INIT_FLAG, 8'd8, 16'sh8000},
      '{BTN, 8'd11, 16'sh7FFF},
      '{BTN, 8'd12, 16'sd1},
      '{BTN, 8'd255, -16'sd1},
      '{BTN, 8'd0, 16'sd0},
      '{AXS, AXIS_LEFT_X, 16'sh8000},
      '{AXS, AXIS_LEFT_Y, 16'sh7FFF},
      '{AXS, AXIS_RIGHT_X, 16'sd0},
      '{AXS, AXIS_RIGHT_Y, -16'sd1},
      '{AXS, AXIS_TRIG_L, TRIG_THRESHOLD_RESET},
      '{AXS, AXIS_TRIG_L, TRIG_THRESHOLD_RESET + 16'sd1},
      '{AXS, AXIS_TRIG_R, 16'sh7FFF},
      '{AXS, AXIS_HAT_HORIZ, HAT_AXIS_POS},
      '{AXS, AXIS_HAT_VERT, HAT_AXIS_POS},
      '{AXS, AXIS_HAT_HORIZ, 16'sh8000},
      '{AXS, AXIS_HAT_VERT, 16'sd0},
      '{AXS, AXIS_HAT_HORIZ, HAT_AXIS_NEG},
      '{AXS, AXIS_HAT_VERT, HAT_AXIS_NEG},
      '{AXS, 8'd8, 16'sd100},
      '{AXS | INIT_FLAG, 8'd255, 16'sd5},
      '{8'h00, 8'd0, 16'sd1},
      '{8'hFF, AXIS_HAT_HORIZ, HAT_AXIS_POS},
      '{8'h03, 8'd1, 16'sd1}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i]) send_event(opening[i]);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_threshold(levels[p]);
      src_idle_en  = (p != PHASES - 1) && (p % 3 != 2);
      sink_idle_en = (p != PHASES - 1) && (p % 3 != 1);
      if (p == 1) long_hold_pending = 1'b1;
      repeat (PHASE_LEN) send_event(random_event());
    end

    wait_idle();
    if (shadow.mismatch_count == 0 && shadow.pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
